// ===== hw/rtl/scfp_pkg.sv =====
package scfp_pkg;

  localparam int unsigned FrameLen   = 32;
  localparam int unsigned PosW       = 6;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned ServoCount = 9;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChrW     = 8'h57;
  localparam logic [7:0] ChrR     = 8'h52;
  localparam logic [7:0] ChrE     = 8'h45;
  localparam logic [7:0] ChrF     = 8'h46;
  localparam logic [7:0] ChrComma = 8'h2C;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;

  localparam logic [PosW-1:0] HdrCheckPos = 6'd3;
  localparam logic [PosW-1:0] LastPos     = 6'd31;
  localparam logic [3:0]      NeededCommas = 4'd10;
  localparam logic [3:0]      CommaMax     = 4'd15;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    digit_t tens;
    digit_t units;
  } digit_pair_t;

  typedef digit_pair_t [ServoCount-1:0] frame_digits_t;

  typedef logic [6:0] servo_val_t;
  typedef servo_val_t [ServoCount-1:0] servo_vals_t;

  // Buffer index of the tens digit of servo field k.
  function automatic logic [IdxW-1:0] field_start(input int unsigned k);
    return IdxW'(4 + 3 * k);
  endfunction

  // Non-digit characters decode as zero.
  function automatic digit_t digit_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - ChrZero;
    if (c >= ChrZero && c <= ChrNine) begin
      return digit_t'(diff);
    end
    return '0;
  endfunction

  // tens * 10 + units, built from shifts.
  function automatic servo_val_t pair_value(input digit_pair_t p);
    return servo_val_t'({p.tens, 3'b000}) + servo_val_t'({p.tens, 1'b0}) +
           servo_val_t'(p.units);
  endfunction

endpackage

// ===== hw/rtl/scfp_front.sv =====
module scfp_front import scfp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  output logic          rx_ready_o,
  input  logic [7:0]    rx_byte_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output frame_digits_t push_data_o
);

  logic [7:0]      frame_q [FrameLen];
  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [3:0]      comma_q, comma_d, comma_eff;
  logic            hdr_q, hdr_d, hdr_eff;
  logic            store_q, store_d, store_eff;
  logic            fire, restart, hdr_bad, check_now, frame_done, wr_en;

  assign rx_ready_o = push_ready_i;
  assign fire       = rx_valid_i && push_ready_i;
  assign restart    = (rx_byte_i == ChrW);

  always_comb begin
    pos_eff   = restart ? '0 : pos_q;
    comma_eff = restart ? '0 : comma_q;
    hdr_eff   = restart ? 1'b1 : hdr_q;
    store_eff = restart ? 1'b1 : store_q;

    comma_d = comma_eff;
    if (rx_byte_i == ChrComma && comma_eff != CommaMax) begin
      comma_d = comma_eff + 4'd1;
    end

    // Header bytes sit below both check positions, so the stored copy is current.
    hdr_bad   = (frame_q[0] != ChrW) || (frame_q[1] != ChrR) || (frame_q[2] != ChrE);
    check_now = (pos_eff == HdrCheckPos) || (pos_eff == LastPos);
    hdr_d     = (check_now && hdr_bad) ? 1'b0 : hdr_eff;

    frame_done = (rx_byte_i == ChrF) && (pos_eff == LastPos) && hdr_d &&
                 (comma_d == NeededCommas);
    store_d    = frame_done ? 1'b0 : store_eff;

    // Saturate at the buffer length; writes there are dropped.
    pos_d = pos_eff[PosW-1] ? pos_eff : pos_eff + 1'b1;
    wr_en = store_eff && !pos_eff[PosW-1];
  end

  always_comb begin
    for (int k = 0; k < ServoCount; k++) begin
      push_data_o[k].tens  = digit_of(frame_q[field_start(k)]);
      push_data_o[k].units = digit_of(frame_q[field_start(k) + 1'b1]);
    end
  end

  assign push_valid_o = rx_valid_i && frame_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      comma_q <= '0;
      hdr_q   <= 1'b1;
      store_q <= 1'b1;
      for (int i = 0; i < FrameLen; i++) begin
        frame_q[i] <= ChrZero;
      end
    end else if (fire) begin
      pos_q   <= pos_d;
      comma_q <= comma_d;
      hdr_q   <= hdr_d;
      store_q <= store_d;
      if (wr_en) begin
        frame_q[pos_eff[IdxW-1:0]] <= rx_byte_i;
      end
    end
  end

endmodule

// ===== hw/rtl/scfp_queue.sv =====
module scfp_queue import scfp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  frame_digits_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output frame_digits_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  frame_digits_t       mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/scfp_back.sv =====
module scfp_back import scfp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  frame_digits_t pop_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output servo_vals_t   out_vals_o
);

  logic        valid_q;
  servo_vals_t vals_q, vals_d;

  assign pop_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_vals_o  = vals_q;

  always_comb begin
    for (int k = 0; k < ServoCount; k++) begin
      vals_d[k] = pair_value(pop_data_i[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) begin
      vals_q <= vals_d;
    end
  end

endmodule

// ===== hw/rtl/servo_command_frame_parser_unit.sv =====
// Result path: on the closing 'F' the front writes the frame into the queue, then the back
//   registers the decoded values before a result transfer is offered.
// Throughput: one byte per cycle; rx_ready_o drops only while the two-entry queue
//   and the output register all hold undelivered frames.
// Reset: rst_ni is asynchronous, active low; it empties queue and output, clears
//   position and comma count, sets header and store flags, and fills the buffer with '0'.
module servo_command_frame_parser_unit import scfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       servo_valid_o,
  input  logic       servo_ready_i,
  output logic [6:0] servo_one_o,
  output logic [6:0] servo_two_o,
  output logic [6:0] servo_three_o,
  output logic [6:0] servo_four_o,
  output logic [6:0] servo_five_o,
  output logic [6:0] servo_six_o,
  output logic [6:0] servo_seven_o,
  output logic [6:0] servo_eight_o,
  output logic [6:0] servo_nine_o
);

  // Front to queue: one entry per accepted frame, holding the eighteen decoded digits.
  logic          push_valid, push_ready;
  frame_digits_t push_data;
  // Queue to back.
  logic          pop_valid, pop_ready;
  frame_digits_t pop_data;
  servo_vals_t   vals;

  // Front: track position, commas, header and store flags; capture the buffer
  // and flag a frame on a valid closing 'F'. It stalls only when the queue is full.
  scfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Queue: decouple byte intake from the result consumer.
  scfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: turn digit pairs into values and hold them until the transfer completes.
  scfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (servo_valid_o),
    .out_ready_i (servo_ready_i),
    .out_vals_o  (vals)
  );

  assign servo_one_o   = vals[0];
  assign servo_two_o   = vals[1];
  assign servo_three_o = vals[2];
  assign servo_four_o  = vals[3];
  assign servo_five_o  = vals[4];
  assign servo_six_o   = vals[5];
  assign servo_seven_o = vals[6];
  assign servo_eight_o = vals[7];
  assign servo_nine_o  = vals[8];

endmodule

// ===== hw/rtl/scfp_checker.sv =====
module scfp_checker import scfp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_o,
  input logic [7:0] rx_byte_i,
  input logic       servo_valid_o,
  input logic       servo_ready_i,
  input logic [6:0] servo_one_o,
  input logic [6:0] servo_two_o,
  input logic [6:0] servo_three_o,
  input logic [6:0] servo_four_o,
  input logic [6:0] servo_five_o,
  input logic [6:0] servo_six_o,
  input logic [6:0] servo_seven_o,
  input logic [6:0] servo_eight_o,
  input logic [6:0] servo_nine_o
);

  localparam logic [6:0] MaxVal = 7'd99;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    servo_valid_o && !servo_ready_i |=> servo_valid_o)
    else $error("result valid dropped before transfer");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    servo_valid_o && !servo_ready_i |=> $stable(servo_one_o) && $stable(servo_five_o) &&
      $stable(servo_nine_o))
    else $error("result payload changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    servo_valid_o |-> servo_one_o <= MaxVal && servo_two_o <= MaxVal &&
      servo_three_o <= MaxVal && servo_four_o <= MaxVal && servo_five_o <= MaxVal &&
      servo_six_o <= MaxVal && servo_seven_o <= MaxVal && servo_eight_o <= MaxVal &&
      servo_nine_o <= MaxVal)
    else $error("servo value above 99");

  a_result_after_f: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(servo_valid_o) |-> $past(rx_valid_i && rx_ready_o && rx_byte_i == ChrF, 2))
    else $error("result without a closing byte two cycles earlier");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> servo_valid_o)
    else $error("input stalled while output register empty");

endmodule

bind servo_command_frame_parser_unit scfp_checker u_scfp_checker (.*);

// ===== tb/sv/scfp_frame_checker.sv =====
module scfp_frame_checker import scfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        servo_valid_i,
  input  logic        servo_ready_i,
  input  servo_vals_t servo_vals_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 10;

  // Shadow copy of the parser state.
  logic [7:0]      frame_mem [FrameLen];
  logic [PosW-1:0] wr_pos;
  logic            hdr_ok;
  logic            storing;
  logic [3:0]      commas;

  servo_vals_t decoded_q [$];
  int unsigned fail_total;
  int unsigned reported;

  function automatic servo_val_t two_digit_value(input logic [7:0] tens_c,
                                                 input logic [7:0] units_c);
    servo_val_t tens_v;
    servo_val_t units_v;
    tens_v  = '0;
    units_v = '0;
    if (tens_c >= ChrZero && tens_c <= ChrNine) tens_v = servo_val_t'(tens_c - ChrZero);
    if (units_c >= ChrZero && units_c <= ChrNine) units_v = servo_val_t'(units_c - ChrZero);
    return servo_val_t'(tens_v * 7'd10 + units_v);
  endfunction

  task automatic note_failure(input string what, input int exp_v, input int act_v);
    fail_total++;
    if (reported < MaxReports) begin
      reported++;
      $display("%0t: %s: expected %0d, actual %0d", $realtime, what, exp_v, act_v);
    end
  endtask

  // Advance the shadow state by one received byte; queue a frame on acceptance.
  task automatic parse_rx_byte(input logic [7:0] b);
    servo_vals_t     vals;
    logic [IdxW-1:0] p;
    if (b == ChrW) begin
      wr_pos  = '0;
      hdr_ok  = 1'b1;
      commas  = '0;
      storing = 1'b1;
    end
    if (b == ChrComma && commas != CommaMax) commas = commas + 4'd1;
    if (storing && wr_pos < FrameLen) frame_mem[wr_pos[IdxW-1:0]] = b;
    if (wr_pos == HdrCheckPos || wr_pos == LastPos) begin
      if (frame_mem[0] != ChrW || frame_mem[1] != ChrR || frame_mem[2] != ChrE) begin
        hdr_ok = 1'b0;
      end
    end
    if (b == ChrF && wr_pos == LastPos && hdr_ok && commas == NeededCommas) begin
      storing = 1'b0;
      for (int k = 0; k < ServoCount; k++) begin
        p = IdxW'(4 + 3 * k);
        vals[k] = two_digit_value(frame_mem[p], frame_mem[p + 1'b1]);
      end
      decoded_q.push_back(vals);
    end
    if (wr_pos < FrameLen) wr_pos = wr_pos + 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    servo_vals_t expected;
    if (!rst_ni) begin
      for (int i = 0; i < FrameLen; i++) frame_mem[i] = ChrZero;
      wr_pos     = '0;
      hdr_ok     = 1'b1;
      commas     = '0;
      storing    = 1'b1;
      decoded_q.delete();
      fail_total = 0;
      reported   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Check the result first: it can only belong to an older frame.
      if (servo_valid_i && servo_ready_i) begin
        if (decoded_q.size() == 0) begin
          note_failure("result with no frame pending", 0, 1);
        end else begin
          expected = decoded_q.pop_front();
          for (int k = 0; k < ServoCount; k++) begin
            if (servo_vals_i[k] !== expected[k]) begin
              note_failure($sformatf("servo %0d mismatch", k + 1),
                           expected[k], servo_vals_i[k]);
            end
          end
        end
      end
      if (rx_valid_i && rx_ready_i) parse_rx_byte(rx_byte_i);
      fail_count_o <= fail_total;
      pending_o    <= decoded_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scfp_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned TargetBytes = 1900;
  localparam int unsigned MinFrames   = 40;
  // Stop idling once this many bytes have gone out.
  localparam int unsigned QuietFrom   = 1550;
  // Drain the result path once around here.
  localparam int unsigned DrainAt     = 900;
  localparam int unsigned TailCycles  = 20;

  logic clk;
  logic rst_n;
  logic rx_valid;
  logic rx_ready;
  logic [7:0] rx_byte;
  logic servo_valid;
  logic servo_ready;
  logic [6:0] servo_one, servo_two, servo_three, servo_four, servo_five;
  logic [6:0] servo_six, servo_seven, servo_eight, servo_nine;
  servo_vals_t servo_vals;

  int unsigned fail_count;
  int unsigned pending;

  // Shared idling switch for sender and receiver.
  bit gaps_on;

  logic [7:0] frame_buf [FrameLen];
  logic [7:0] rx_stream_q [$];
  int unsigned bytes_sent;
  int unsigned good_frames;
  int unsigned idle_cycles;

  servo_command_frame_parser_unit uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .rx_valid_i    (rx_valid),
    .rx_ready_o    (rx_ready),
    .rx_byte_i     (rx_byte),
    .servo_valid_o (servo_valid),
    .servo_ready_i (servo_ready),
    .servo_one_o   (servo_one),
    .servo_two_o   (servo_two),
    .servo_three_o (servo_three),
    .servo_four_o  (servo_four),
    .servo_five_o  (servo_five),
    .servo_six_o   (servo_six),
    .servo_seven_o (servo_seven),
    .servo_eight_o (servo_eight),
    .servo_nine_o  (servo_nine)
  );

  // Index 0 of the packed array is the first servo.
  assign servo_vals = {servo_nine, servo_eight, servo_seven, servo_six, servo_five,
                       servo_four, servo_three, servo_two, servo_one};

  scfp_frame_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .rx_valid_i    (rx_valid),
    .rx_ready_i    (rx_ready),
    .rx_byte_i     (rx_byte),
    .servo_valid_i (servo_valid),
    .servo_ready_i (servo_ready),
    .servo_vals_i  (servo_vals),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((rx_valid && rx_ready) || (servo_valid && servo_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: accept by default; while gaps_on is set, sometimes stall for a random burst.
  initial begin
    int unsigned stall_left;
    servo_ready = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        servo_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left  = $urandom_range(1, 5) - 1;
        servo_ready <= 1'b0;
      end else begin
        servo_ready <= 1'b1;
      end
    end
  end

  // Digit bytes mostly, now and then any byte that neither restarts nor counts.
  function automatic logic [7:0] rand_digit_byte();
    logic [7:0] b;
    if ($urandom_range(0, 6) != 0) return ChrZero + 8'($urandom_range(0, 9));
    b = 8'($urandom_range(0, 255));
    while (b == ChrW || b == ChrComma) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] rand_non_restart();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == ChrW) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Lay out a well-formed frame: header, ten commas around nine digit pairs, 'F' last.
  task automatic fill_frame();
    frame_buf[0] = ChrW;
    frame_buf[1] = ChrR;
    frame_buf[2] = ChrE;
    for (int k = 0; k < ServoCount; k++) begin
      frame_buf[3 + 3 * k] = ChrComma;
      frame_buf[4 + 3 * k] = rand_digit_byte();
      frame_buf[5 + 3 * k] = rand_digit_byte();
    end
    frame_buf[30] = ChrComma;
    frame_buf[31] = ChrF;
  endtask

  task automatic queue_frame(input int unsigned n);
    for (int i = 0; i < n; i++) rx_stream_q.push_back(frame_buf[i]);
  endtask

  // Offer one byte: maybe drop valid for a gap first, then hold it until the transfer.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_stream();
    while (rx_stream_q.size() > 0) send_byte(rx_stream_q.pop_front());
  endtask

  initial begin
    int unsigned kind;
    int unsigned n;
    bit drained;
    rst_n       = 1'b0;
    rx_valid    = 1'b0;
    rx_byte     = '0;
    gaps_on     = 1'b1;
    drained     = 1'b0;
    bytes_sent  = 0;
    good_frames = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extreme bytes, an 'F' far from the end, then one frame with
    // full-scale, zero and boundary non-digit pairs, then bytes after acceptance.
    rx_stream_q.push_back(8'h00);
    rx_stream_q.push_back(8'hFF);
    rx_stream_q.push_back(ChrF);
    fill_frame();
    frame_buf[4]  = ChrNine;      frame_buf[5]  = ChrNine;
    frame_buf[7]  = ChrZero;      frame_buf[8]  = ChrZero;
    frame_buf[10] = ChrZero - 8'd1; frame_buf[11] = ChrNine;
    frame_buf[13] = ChrNine;      frame_buf[14] = ChrNine + 8'd1;
    frame_buf[16] = 8'hFF;        frame_buf[17] = 8'h00;
    queue_frame(FrameLen);
    rx_stream_q.push_back(ChrF);
    rx_stream_q.push_back(ChrComma);
    send_stream();

    // Random: mostly good frames with random payload, the rest broken or noise.
    while (bytes_sent < TargetBytes || good_frames < MinFrames) begin
      if (bytes_sent > QuietFrom) gaps_on = 1'b0;
      if (!drained && bytes_sent > DrainAt) begin
        // Hold off until every decoded frame has come out.
        drained = 1'b1;
        rx_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      kind = $urandom_range(0, 9);
      fill_frame();
      if (kind <= 5) begin
        queue_frame(FrameLen);
        good_frames++;
        // Trailing bytes land while storing is off.
        n = $urandom_range(0, 3);
        repeat (n) rx_stream_q.push_back(rand_non_restart());
      end else if (kind == 6) begin
        frame_buf[$urandom_range(0, 31)] = 8'($urandom_range(0, 255));
        queue_frame(FrameLen);
      end else if (kind == 7) begin
        frame_buf[$urandom_range(1, 2)] = 8'($urandom_range(0, 255));
        queue_frame(FrameLen);
      end else if (kind == 8) begin
        // Push the closing 'F' past the last position; the position saturates.
        queue_frame(FrameLen - 1);
        n = $urandom_range(1, 4);
        repeat (n) rx_stream_q.push_back(rand_non_restart());
        rx_stream_q.push_back(ChrF);
      end else if ($urandom_range(0, 1) == 0) begin
        // Comma flood, enough to saturate the count.
        rx_stream_q.push_back(ChrW);
        n = $urandom_range(12, 20);
        repeat (n) rx_stream_q.push_back(ChrComma);
        for (int i = 1; i < FrameLen; i++) rx_stream_q.push_back(frame_buf[i]);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) rx_stream_q.push_back(8'($urandom_range(0, 255)));
      end
      send_stream();
    end

    rx_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== servo_command_frame_parser_unit.f =====
hw/rtl/scfp_pkg.sv
hw/rtl/scfp_front.sv
hw/rtl/scfp_queue.sv
hw/rtl/scfp_back.sv
hw/rtl/servo_command_frame_parser_unit.sv
hw/rtl/scfp_checker.sv
tb/sv/scfp_frame_checker.sv
tb/sv/tb.sv
